// ----- src/rcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcm_pkg: shared types, constants and functions for the rounded corner mask
// Holds the register map, the transaction payloads passed between the front,
// the queue and the back, and the arithmetic steps used in the back pipeline.
// ----------------------------------------------------------------------------
package rcm_pkg;

	// frame geometry
	localparam int MAX_DIM     = 2048;
	localparam int DIM_W       = 12;
	localparam int POS_W       = 11;
	localparam int RAD_W       = 11;
	localparam int FRAC_BITS   = 8;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int COEF_W      = FRAC_BITS + 1;

	// automatic radius: (m + 9) / 10 as a multiply by 2^15/10, rounded up
	localparam int AUTO_BIAS   = 9;
	localparam int AUTO_SHIFT  = 15;
	localparam int AUTO_RECIP  = ((1 << AUTO_SHIFT) + 9) / 10;

	// distance arithmetic
	localparam int SQ_W        = 2 * RAD_W;           // i*i + j*j
	localparam int N_W         = SQ_W + 2 * FRAC_BITS; // radicand width
	localparam int ROOT_W      = N_W / 2;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int REM_W       = ROOT_W + 3;
	localparam int D_W         = ROOT_W + 2;

	// queue between front and back
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;

	// register map
	localparam int PADDR_W     = 5;
	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_CORNER_RADIUS = 3'd2;
	localparam logic [2:0] REG_BORDER_ENABLE = 3'd3;
	localparam logic [2:0] REG_BORDER_COLOR  = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [DIM_W-1:0] corner_radius;
		logic             border_enable;
		logic [31:0]      brd_rgba;
	} cfg_t;

	// one transaction leaving the front
	typedef struct packed {
		logic [31:0]     pix;
		logic [SQ_W-1:0] sq;
		logic [RAD_W-1:0] r;
		logic [2:0]      nq;
		logic            edge_px;
	} fq_t;

	// transaction inside the square-root pipeline
	typedef struct packed {
		fq_t               item;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqp_t;

	typedef enum logic [1:0] {
		CLS_KEEP,
		CLS_CLEAR,
		CLS_FADE,
		CLS_BLEND
	} cls_t;

	// transaction in the shading stages
	typedef struct packed {
		logic [31:0]       pix;
		logic [2:0]        nq;
		logic              edge_px;
		cls_t              cls;
		logic [COEF_W-1:0] c0;
		logic [31:0]       bprod;
	} sh_t;

	// one digit of the square root, two radicand bits brought down
	function automatic sqp_t sqrt_step(sqp_t s, int k);
		logic [N_W-1:0]    n;
		logic [1:0]        pair;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		sqp_t              o;
		n      = {s.item.sq, {(2*FRAC_BITS){1'b0}}};
		pair   = 2'(n >> (N_W - 2 - 2 * k));
		rem_sh = {s.rem[REM_W-3:0], pair};
		trial  = REM_W'({s.root, 2'b01});
		o      = s;
		if (rem_sh >= trial) begin
			o.rem  = rem_sh - trial;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = rem_sh;
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// truncated fixed-point product of a byte and a coefficient
	function automatic logic [7:0] fx_mul(logic [7:0] a, logic [COEF_W-1:0] c);
		logic [7+COEF_W:0] p;
		p = {{COEF_W{1'b0}}, a} * {8'd0, c};
		return p[FRAC_BITS +: 8];
	endfunction

	// one application of the corner rule to a pixel
	function automatic logic [31:0] shade(sh_t s, logic [7:0] alpha_c, logic brd,
			logic [31:0] bc);
		logic [31:0] p;
		logic [7:0]  a;
		p = s.pix;
		case (s.cls)
			CLS_KEEP: p = s.pix;
			CLS_CLEAR: p[31:24] = 8'd0;
			CLS_FADE: begin
				if (brd) begin
					p = {s.bprod[31:24], bc[23:0]};
				end else begin
					p[31:24] = alpha_c;
				end
			end
			CLS_BLEND: begin
				for (int k = 0; k < 3; k++) begin
					p[8*k +: 8] = s.bprod[8*k +: 8] + fx_mul(s.pix[8*k +: 8], s.c0);
				end
				a = s.pix[31:24];
				p[31:24] = (s.bprod[31:24] > a) ? s.bprod[31:24] : a;
			end
			default: p = s.pix;
		endcase
		return p;
	endfunction

endpackage

// ----- src/rounded_corner_mask.sv -----
// Throughput: one pixel per cycle while out_stall is low; the 19-stage
// square-root pipeline and four corner passes are fully pipelined, with a
// 4-entry queue between classifier and shader.
// Reset: asynchronous, clears all valid flags and queue pointers; the config
// registers go to their defaults (64 x 64 frame, automatic radius, no border).
// ----------------------------------------------------------------------------
// rounded_corner_mask: antialiased rounded corner mask
// Reshapes the alpha of corner pixels by their distance from a circular arc
// and optionally draws a border colour along the arcs and straight edges.
// ----------------------------------------------------------------------------
module rounded_corner_mask (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [31:0]                 pixel_in,
	input  logic [rcm_pkg::POS_W-1:0]   x_pos,
	input  logic [rcm_pkg::POS_W-1:0]   y_pos,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [31:0]                 pixel_out
);

	rcm_pkg::cfg_t cfg;
	rcm_pkg::fq_t  push_data, pop_data;
	logic          push, full, pop, empty;

	rcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.push      (push),
		.full      (full),
		.push_data (push_data)
	);

	rcm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	rcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out)
	);

endmodule

// ----- src/rcm_cfg.sv -----
// ----------------------------------------------------------------------------
// rcm_cfg: register block
// APB-style slave holding frame size, radius and border settings.
// ----------------------------------------------------------------------------
module rcm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output rcm_pkg::cfg_t               cfg
);

	rcm_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= rcm_pkg::DIM_W'(64);
			cfg_q.frame_height  <= rcm_pkg::DIM_W'(64);
			cfg_q.corner_radius <= '1;
			cfg_q.border_enable <= 1'b0;
			cfg_q.brd_rgba      <= '0;
		end else if (wr_en) begin
			case (paddr[4:2])
				rcm_pkg::REG_FRAME_WIDTH:   cfg_q.frame_width   <= pwdata[rcm_pkg::DIM_W-1:0];
				rcm_pkg::REG_FRAME_HEIGHT:  cfg_q.frame_height  <= pwdata[rcm_pkg::DIM_W-1:0];
				rcm_pkg::REG_CORNER_RADIUS: cfg_q.corner_radius <= pwdata[rcm_pkg::DIM_W-1:0];
				rcm_pkg::REG_BORDER_ENABLE: cfg_q.border_enable <= pwdata[0];
				rcm_pkg::REG_BORDER_COLOR:  cfg_q.brd_rgba      <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[4:2])
			rcm_pkg::REG_FRAME_WIDTH:   prdata = 32'(cfg_q.frame_width);
			rcm_pkg::REG_FRAME_HEIGHT:  prdata = 32'(cfg_q.frame_height);
			rcm_pkg::REG_CORNER_RADIUS: prdata = 32'(cfg_q.corner_radius);
			rcm_pkg::REG_BORDER_ENABLE: prdata = 32'(cfg_q.border_enable);
			rcm_pkg::REG_BORDER_COLOR:  prdata = cfg_q.brd_rgba;
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/rcm_front.sv -----
// ----------------------------------------------------------------------------
// rcm_front: pixel classifier
// Works out the radius, the corner offsets, the number of covering corner
// squares and the straight-edge flag, and forms i*i + j*j.
// ----------------------------------------------------------------------------
module rcm_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rcm_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [31:0]               pixel_in,
	input  logic [rcm_pkg::POS_W-1:0] x_pos,
	input  logic [rcm_pkg::POS_W-1:0] y_pos,
	output logic                      push,
	input  logic                      full,
	output rcm_pkg::fq_t              push_data
);

	localparam int DW = rcm_pkg::DIM_W;
	localparam int RW = rcm_pkg::RAD_W;
	localparam int SW = DW + 1;

	logic en;
	logic v_s1, v_s2, v_s3;

	// frame size and radius
	logic [DW-1:0]    w, h, mn, half;
	logic [DW+DW-1:0] auto_p;
	logic [RW-1:0]    r_c;

	always_comb begin
		w      = (cfg.frame_width > DW'(rcm_pkg::MAX_DIM)) ? DW'(rcm_pkg::MAX_DIM)
			: cfg.frame_width;
		h      = (cfg.frame_height > DW'(rcm_pkg::MAX_DIM)) ? DW'(rcm_pkg::MAX_DIM)
			: cfg.frame_height;
		mn     = (w < h) ? w : h;
		half   = DW'((13'(mn) + 13'd1) >> 1);
		auto_p = (mn + DW'(rcm_pkg::AUTO_BIAS)) * DW'(rcm_pkg::AUTO_RECIP);
		if (cfg.corner_radius[DW-1]) begin
			r_c = RW'(auto_p >> rcm_pkg::AUTO_SHIFT);
		end else if (cfg.corner_radius < half) begin
			r_c = RW'(cfg.corner_radius);
		end else begin
			r_c = RW'(half);
		end
	end

	// stage 1: input capture
	logic [31:0]           pix_s1;
	logic [RW-1:0]         x_s1, y_s1, r_s1;

	// stage 2: offsets and flags
	logic [31:0]           pix_s2;
	logic [RW-1:0]         i_s2, j_s2, r_s2;
	logic [2:0]            nq_s2;
	logic                  edge_s2;

	// stage 3: squares
	logic [31:0]           pix_s3;
	logic [rcm_pkg::SQ_W-1:0] ii_s3, jj_s3;
	logic [RW-1:0]         r_s3;
	logic [2:0]            nq_s3;
	logic                  edge_s3;

	assign en       = !v_s3 || !full;
	assign in_stall = !en;
	assign push     = v_s3 && !full;

	// classification of the captured pixel
	logic [SW-1:0] xs, ys, rs, ws, hs;
	logic          in_frame, top, bot, lft, rgt, on_row, on_col;
	logic [SW-1:0] i_c, j_c;
	logic [2:0]    nq_c;

	always_comb begin
		xs       = SW'(x_s1);
		ys       = SW'(y_s1);
		rs       = SW'(r_s1);
		ws       = SW'(w);
		hs       = SW'(h);
		in_frame = (xs < ws) && (ys < hs);
		top      = ys < rs;
		bot      = ys >= hs - rs;
		lft      = xs < rs;
		rgt      = xs >= ws - rs;
		i_c      = top ? rs - ys : rs - hs + SW'(1) + ys;
		j_c      = lft ? rs - xs : rs - ws + SW'(1) + xs;
		nq_c     = 3'(top && rgt) + 3'(top && lft) + 3'(bot && lft) + 3'(bot && rgt);
		if (!in_frame) begin
			nq_c = 3'd0;
		end
		on_row = (ys == 0 || ys == hs - SW'(1)) && xs >= rs && xs + rs + SW'(1) <= ws;
		on_col = (xs == 0 || xs == ws - SW'(1)) && ys >= rs && ys + rs + SW'(1) <= hs;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= pixel_in;
			x_s1    <= x_pos;
			y_s1    <= y_pos;
			r_s1    <= r_c;

			pix_s2  <= pix_s1;
			i_s2    <= RW'(i_c);
			j_s2    <= RW'(j_c);
			r_s2    <= r_s1;
			nq_s2   <= nq_c;
			edge_s2 <= cfg.border_enable && in_frame && (on_row || on_col);

			pix_s3  <= pix_s2;
			ii_s3   <= rcm_pkg::SQ_W'(i_s2) * rcm_pkg::SQ_W'(i_s2);
			jj_s3   <= rcm_pkg::SQ_W'(j_s2) * rcm_pkg::SQ_W'(j_s2);
			r_s3    <= r_s2;
			nq_s3   <= nq_s2;
			edge_s3 <= edge_s2;
		end
	end

	always_comb begin
		push_data.pix     = pix_s3;
		push_data.sq      = ii_s3 + jj_s3;
		push_data.r       = r_s3;
		push_data.nq      = nq_s3;
		push_data.edge_px = edge_s3;
	end

endmodule

// ----- src/rcm_fifo.sv -----
// ----------------------------------------------------------------------------
// rcm_fifo: transaction queue
// Short first-in first-out store decoupling the classifier from the shader.
// ----------------------------------------------------------------------------
module rcm_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  rcm_pkg::fq_t push_data,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output rcm_pkg::fq_t pop_data
);

	localparam int AW = rcm_pkg::FIFO_AW;

	rcm_pkg::fq_t  mem_q [rcm_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	assign full     = count_q == (AW+1)'(rcm_pkg::FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ----- src/rcm_back.sv -----
// ----------------------------------------------------------------------------
// rcm_back: corner shader
// Pipelined square root, distance classification, border products, up to
// four corner passes and the straight-edge replacement.
// ----------------------------------------------------------------------------
module rcm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rcm_pkg::cfg_t cfg,
	input  logic          empty,
	input  rcm_pkg::fq_t  pop_data,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   pixel_out
);

	localparam int NS = rcm_pkg::SQRT_STAGES;
	localparam int CW = rcm_pkg::COEF_W;
	localparam int DW = rcm_pkg::D_W;
	localparam logic signed [DW-1:0] D_ONE = DW'(rcm_pkg::ONE);

	logic en;

	// square-root pipeline, entry 0 is the transaction taken from the queue
	logic          v_sq [NS+1];
	rcm_pkg::sqp_t sq_s [NS+1];

	// classification stage and border product stage
	logic          v_cl;
	logic [31:0]   pix_cl;
	logic [2:0]    nq_cl;
	logic          edge_cl;
	rcm_pkg::cls_t cls_cl;
	logic [CW-1:0] cf_cl, c0_cl;

	// shading stages, entry 0 leaves the border product stage
	logic          v_sh [5];
	rcm_pkg::sh_t  sh_s [5];
	rcm_pkg::sh_t  sh_n [4];

	logic          out_v_q;
	logic [31:0]   out_q;

	assign en        = !out_v_q || !out_stall;
	assign pop       = en && !empty;
	assign out_valid = out_v_q;
	assign pixel_out = out_q;

	// coefficient for the alpha in the fade rule, carried in c0
	function automatic logic [CW-1:0] cf_of(rcm_pkg::sh_t s);
		return s.c0;
	endfunction

	// distance from the arc
	logic signed [DW-1:0] d;
	rcm_pkg::cls_t        cls_c;
	logic [CW-1:0]        cf_c, c0_c;

	always_comb begin
		d = $signed(DW'(sq_s[NS].root)) -
			$signed(DW'({sq_s[NS].item.r, {rcm_pkg::FRAC_BITS{1'b0}}}));
		cf_c = '0;
		c0_c = '0;
		if (d < -D_ONE) begin
			cls_c = rcm_pkg::CLS_KEEP;
		end else if (d >= D_ONE) begin
			cls_c = rcm_pkg::CLS_CLEAR;
		end else if (d > 0) begin
			cls_c = rcm_pkg::CLS_FADE;
			cf_c  = CW'(D_ONE - d);
			c0_c  = CW'(D_ONE - d);
		end else begin
			cls_c = cfg.border_enable ? rcm_pkg::CLS_BLEND : rcm_pkg::CLS_KEEP;
			cf_c  = CW'(d + D_ONE);
			c0_c  = CW'(-d);
		end
	end

	// border colour scaled by the coefficient
	logic [31:0] bprod_c;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			bprod_c[8*k +: 8] = rcm_pkg::fx_mul(cfg.brd_rgba[8*k +: 8], cf_cl);
		end
	end

	// one corner pass per stage, for each square covering the pixel
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sh_n[k] = sh_s[k];
			if (sh_s[k].nq > 3'(k)) begin
				sh_n[k].pix = rcm_pkg::shade(sh_s[k],
					rcm_pkg::fx_mul(sh_s[k].pix[31:24], cf_of(sh_s[k])),
					cfg.border_enable, cfg.brd_rgba);
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) v_sq[k] <= 1'b0;
			for (int k = 0; k < 5; k++)   v_sh[k] <= 1'b0;
			v_cl    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_sq[0] <= pop;
			for (int k = 1; k <= NS; k++) v_sq[k] <= v_sq[k-1];
			v_cl    <= v_sq[NS];
			v_sh[0] <= v_cl;
			for (int k = 1; k < 5; k++) v_sh[k] <= v_sh[k-1];
			out_v_q <= v_sh[4];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].item <= pop_data;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			for (int k = 1; k <= NS; k++) begin
				sq_s[k] <= rcm_pkg::sqrt_step(sq_s[k-1], k - 1);
			end

			pix_cl  <= sq_s[NS].item.pix;
			nq_cl   <= sq_s[NS].item.nq;
			edge_cl <= sq_s[NS].item.edge_px;
			cls_cl  <= cls_c;
			cf_cl   <= cf_c;
			c0_cl   <= c0_c;

			sh_s[0].pix     <= pix_cl;
			sh_s[0].nq      <= nq_cl;
			sh_s[0].edge_px <= edge_cl;
			sh_s[0].cls     <= cls_cl;
			sh_s[0].c0      <= c0_cl;
			sh_s[0].bprod   <= bprod_c;

			for (int k = 1; k < 5; k++) begin
				sh_s[k] <= sh_n[k-1];
			end

			out_q <= sh_s[4].edge_px ? cfg.brd_rgba : sh_s[4].pix;
		end
	end

endmodule
